@@ hw/rtl/bpc_pkg.sv @@
// Shared types and codes for the barometric pressure compensation block.
// No dependencies; imported by every module of the block.
package bpc_pkg;

    localparam int COEF_W  = 16;
    localparam int RAW_W   = 24;
    localparam int PRESS_W = 32;

    // Input event codes carried on the mode field
    typedef enum logic [1:0] {
        MODE_PRESS = 2'd0,
        MODE_TEMP  = 2'd1,
        MODE_SYNC  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // Configuration register indexes (word address)
    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5,
        REG_EN = 3'd6
    } t_reg_idx;

    // Calibration words as handed from the register file to the datapath
    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c6;
    } t_coefs;

endpackage

@@ hw/rtl/bpc_front.sv @@
// Front end: accepts event requests, latches raw samples, issues compute jobs.
// Depends on bpc_pkg.
module bpc_front import bpc_pkg::*; #(
    parameter int ADC_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_mode,
    input  logic [RAW_W-1:0]       i_raw_value,
    input  logic                   i_enable,
    input  logic                   i_q_full,
    output logic                   o_push,
    output logic [2*ADC_WIDTH-1:0] o_push_data
);

    logic [ADC_WIDTH-1:0] r_d1;
    logic [ADC_WIDTH-1:0] r_d2;
    logic                 accept;

    assign o_stall     = i_q_full;
    assign accept      = i_valid && !i_q_full;
    // Snapshot the samples so a queued job is immune to later latches
    assign o_push_data = {r_d1, r_d2};

    always_comb begin
        o_push = 1'b0;
        case (t_mode'(i_mode))
            MODE_SYNC: o_push = accept && i_enable;
            default:   o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (accept) begin
            case (t_mode'(i_mode))
                MODE_PRESS: r_d1 <= i_raw_value[ADC_WIDTH-1:0];
                MODE_TEMP:  r_d2 <= i_raw_value[ADC_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/bpc_queue.sv @@
// Short job queue between the front end and the compensation sequencer.
// Depends on bpc_pkg.
module bpc_queue import bpc_pkg::*; #(
    parameter int W     = 48,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/bpc_back.sv @@
// Back end: compensation sequencer around one shared 26x26 signed multiplier,
// plus the result output register. Depends on bpc_pkg.
module bpc_back import bpc_pkg::*; #(
    parameter int ADC_WIDTH = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_coefs               i_coefs,
    input  logic                 i_job_valid,
    input  logic [ADC_WIDTH-1:0] i_job_d1,
    input  logic [ADC_WIDTH-1:0] i_job_d2,
    output logic                 o_job_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PRESS_W-1:0]   o_pressure
);

    localparam int MUL_W      = 26;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 64;
    localparam int WIDE_W     = 40;
    localparam int TEMP_W     = 20;
    localparam int SENS_SPLIT = 20;
    localparam int COEF_SH    = 23;
    localparam int TEMP_SH    = 23;
    localparam int OFF_SH     = 7;
    localparam int SENS_SH    = 8;
    localparam int P_SH       = 36;
    localparam int OFF_P_SH   = 21;
    localparam int C5_SH      = 8;

    localparam logic signed [ACC_W-1:0]  TEMP_BASE = 64'sd2000 * 64'sd8388608;
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -20'sd1500;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'h0001,
        ST_DT     = 14'h0002,
        ST_M_TEMP = 14'h0004,
        ST_M_OFF  = 14'h0008,
        ST_M_SENS = 14'h0010,
        ST_M_T    = 14'h0020,
        ST_M_U7   = 14'h0040,
        ST_M_U11  = 14'h0080,
        ST_ADD    = 14'h0100,
        ST_ADJ    = 14'h0200,
        ST_M_PL   = 14'h0400,
        ST_M_PH   = 14'h0800,
        ST_FIN    = 14'h1000,
        ST_RES    = 14'h2000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [ADC_WIDTH-1:0]       r_d1;
    logic [ADC_WIDTH-1:0]       r_d2;
    logic signed [MUL_W-1:0]    r_dt;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [TEMP_W-1:0]   r_temp;
    logic signed [WIDE_W-1:0]   r_off;
    logic signed [WIDE_W-1:0]   r_sens;
    logic signed [WIDE_W-1:0]   r_off2;
    logic signed [WIDE_W-1:0]   r_sens2;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_valid;
    logic [PRESS_W-1:0]         r_out_press;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]    prod64;
    logic signed [ACC_W-1:0]    prod_h1;
    logic signed [ACC_W-1:0]    prod_q2;
    logic signed [ACC_W-1:0]    off64;
    logic signed [ACC_W-1:0]    c1_sh;
    logic signed [ACC_W-1:0]    c2_sh;
    logic signed [ACC_W-1:0]    temp_q;
    logic signed [ACC_W-1:0]    off_q;
    logic signed [ACC_W-1:0]    sens_q;
    logic signed [ACC_W-1:0]    p_q;
    logic signed [MUL_W-1:0]    dt_next;
    logic signed [TEMP_W-1:0]   t_val;
    logic signed [TEMP_W-1:0]   u_val;
    logic signed [MUL_W-1:0]    t_m;
    logic signed [MUL_W-1:0]    u_m;
    logic                       cold;
    logic                       very_cold;
    logic                       out_free;

    // Divide by 2^sh rounding toward zero
    function automatic logic signed [ACC_W-1:0] trunc_shift(
        input logic signed [ACC_W-1:0] x,
        input int unsigned             sh
    );
        logic signed [ACC_W-1:0] bias;
        bias = x[ACC_W-1] ? ((64'sd1 <<< sh) - 64'sd1) : '0;
        return (x + bias) >>> sh;
    endfunction

    assign out_free   = !r_out_valid || !i_stall;
    assign o_valid    = r_out_valid;
    assign o_pressure = r_out_press;
    assign o_job_pop  = (r_state == ST_IDLE) && i_job_valid;

    assign prod64  = $signed({{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod});
    assign prod_h1 = prod64 >>> 1;
    assign prod_q2 = prod64 >>> 2;
    assign off64   = $signed({{(ACC_W-WIDE_W){r_off[WIDE_W-1]}}, r_off});
    assign c1_sh   = $signed({{(ACC_W-COEF_W-COEF_SH){1'b0}}, i_coefs.c1, {COEF_SH{1'b0}}});
    assign c2_sh   = $signed({{(ACC_W-COEF_W-COEF_SH){1'b0}}, i_coefs.c2, {COEF_SH{1'b0}}});

    assign temp_q = trunc_shift(TEMP_BASE + prod64, TEMP_SH);
    assign off_q  = trunc_shift(c2_sh + prod64, OFF_SH);
    assign sens_q = trunc_shift(c1_sh + prod64, SENS_SH);
    assign p_q    = trunc_shift(r_acc, P_SH);

    assign dt_next = $signed({{(MUL_W-ADC_WIDTH){1'b0}}, r_d2})
                   - $signed({{(MUL_W-COEF_W-C5_SH){1'b0}}, i_coefs.c5, {C5_SH{1'b0}}});

    assign t_val     = r_temp - TEMP_REF;
    assign u_val     = r_temp - TEMP_LOW;
    assign t_m       = $signed({{(MUL_W-TEMP_W){t_val[TEMP_W-1]}}, t_val});
    assign u_m       = $signed({{(MUL_W-TEMP_W){u_val[TEMP_W-1]}}, u_val});
    assign cold      = (r_temp < TEMP_REF);
    assign very_cold = (r_temp < TEMP_LOW);

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_M_TEMP: begin
                mul_a = $signed({{(MUL_W-COEF_W){1'b0}}, i_coefs.c6});
                mul_b = r_dt;
            end
            ST_M_OFF: begin
                mul_a = $signed({{(MUL_W-COEF_W){1'b0}}, i_coefs.c4});
                mul_b = r_dt;
            end
            ST_M_SENS: begin
                mul_a = $signed({{(MUL_W-COEF_W){1'b0}}, i_coefs.c3});
                mul_b = r_dt;
            end
            ST_M_T: begin
                mul_a = (t_m <<< 2) + t_m;
                mul_b = t_m;
            end
            ST_M_U7: begin
                mul_a = (u_m <<< 3) - u_m;
                mul_b = u_m;
            end
            ST_M_U11: begin
                mul_a = (u_m <<< 3) + (u_m <<< 1) + u_m;
                mul_b = u_m;
            end
            ST_M_PL: begin
                mul_a = $signed({{(MUL_W-ADC_WIDTH){1'b0}}, r_d1});
                mul_b = $signed({{(MUL_W-SENS_SPLIT){1'b0}}, r_sens[SENS_SPLIT-1:0]});
            end
            ST_M_PH: begin
                mul_a = $signed({{(MUL_W-ADC_WIDTH){1'b0}}, r_d1});
                mul_b = $signed({{(MUL_W-(WIDE_W-SENS_SPLIT)){r_sens[WIDE_W-1]}},
                                 r_sens[WIDE_W-1:SENS_SPLIT]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   n_state = i_job_valid ? ST_DT : ST_IDLE;
            ST_DT:     n_state = ST_M_TEMP;
            ST_M_TEMP: n_state = ST_M_OFF;
            ST_M_OFF:  n_state = ST_M_SENS;
            ST_M_SENS: n_state = ST_M_T;
            ST_M_T:    n_state = ST_M_U7;
            ST_M_U7:   n_state = ST_M_U11;
            ST_M_U11:  n_state = ST_ADD;
            ST_ADD:    n_state = ST_ADJ;
            ST_ADJ:    n_state = ST_M_PL;
            ST_M_PL:   n_state = ST_M_PH;
            ST_M_PH:   n_state = ST_FIN;
            ST_FIN:    n_state = ST_RES;
            ST_RES:    n_state = out_free ? ST_IDLE : ST_RES;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RES && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath; each product is consumed the cycle after it is issued
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            ST_IDLE: begin
                r_d1 <= i_job_d1;
                r_d2 <= i_job_d2;
            end
            ST_DT:     r_dt   <= dt_next;
            ST_M_OFF:  r_temp <= temp_q[TEMP_W-1:0];
            ST_M_SENS: r_off  <= off_q[WIDE_W-1:0];
            ST_M_T:    r_sens <= sens_q[WIDE_W-1:0];
            ST_M_U7: begin
                r_off2  <= cold ? prod_h1[WIDE_W-1:0] : '0;
                r_sens2 <= cold ? prod_q2[WIDE_W-1:0] : '0;
            end
            ST_M_U11: begin
                if (very_cold) begin
                    r_off2 <= r_off2 + prod64[WIDE_W-1:0];
                end
            end
            ST_ADD: begin
                if (very_cold) begin
                    r_sens2 <= r_sens2 + prod_h1[WIDE_W-1:0];
                end
            end
            ST_ADJ: begin
                r_off  <= r_off - r_off2;
                r_sens <= r_sens - r_sens2;
            end
            ST_M_PH: r_acc <= prod64 - (off64 <<< OFF_P_SH);
            ST_FIN:  r_acc <= r_acc + (prod64 <<< SENS_SPLIT);
            ST_RES: begin
                if (out_free) begin
                    r_out_press <= p_q[PRESS_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hw/rtl/baro_pressure_compensation.sv @@
// Top level of the barometric pressure compensation block: register file,
// front end, job queue and compensation sequencer. Depends on bpc_pkg.
//
// Events arrive on the input channel: mode 0 latches a raw pressure sample,
// mode 1 a raw temperature sample (low ADC_WIDTH bits of raw_value), mode 2
// requests a compensated pressure and mode 3 is dropped. Latch requests are
// taken every cycle while the job queue has room. A sync request, when
// output_enable is set, snapshots both samples into a two-entry queue; with
// output_enable clear it yields nothing. The sequencer takes one job at a
// time through its pop and dT steps, eight products that share a single
// 26x26 signed multiplier (one per cycle, each registered), and its
// correction, final add and result steps. The
// result, in 0.01 mbar as 32-bit two's complement, waits in an output
// register while the front end keeps accepting: behind a stalled result one
// further sync can finish in the sequencer and wait there, and two more can
// sit in the queue; after that the input stalls. Calibration words C1..C6 and
// output_enable sit at byte addresses 0x00..0x18 of the APB port; writes to
// other words are ignored and read back as zero. Write them only while the
// block is idle.
module baro_pressure_compensation import bpc_pkg::*; #(
    parameter int ADC_WIDTH = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // event channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [RAW_W-1:0]   i_raw_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [PRESS_W-1:0] o_pressure,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int JOB_W = 2 * ADC_WIDTH;

    t_coefs             r_coefs;
    logic               r_enable;
    logic               cfg_wr;
    t_reg_idx           reg_idx;

    logic               q_full;
    logic               q_push;
    logic [JOB_W-1:0]   q_push_data;
    logic               q_valid;
    logic               q_pop;
    logic [JOB_W-1:0]   q_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    // Register file: write in the access phase, ignore unknown words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs  <= '0;
            r_enable <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_C1:  r_coefs.c1 <= pwdata[COEF_W-1:0];
                REG_C2:  r_coefs.c2 <= pwdata[COEF_W-1:0];
                REG_C3:  r_coefs.c3 <= pwdata[COEF_W-1:0];
                REG_C4:  r_coefs.c4 <= pwdata[COEF_W-1:0];
                REG_C5:  r_coefs.c5 <= pwdata[COEF_W-1:0];
                REG_C6:  r_coefs.c6 <= pwdata[COEF_W-1:0];
                REG_EN:  r_enable   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_C1:  prdata = {{(32-COEF_W){1'b0}}, r_coefs.c1};
            REG_C2:  prdata = {{(32-COEF_W){1'b0}}, r_coefs.c2};
            REG_C3:  prdata = {{(32-COEF_W){1'b0}}, r_coefs.c3};
            REG_C4:  prdata = {{(32-COEF_W){1'b0}}, r_coefs.c4};
            REG_C5:  prdata = {{(32-COEF_W){1'b0}}, r_coefs.c5};
            REG_C6:  prdata = {{(32-COEF_W){1'b0}}, r_coefs.c6};
            REG_EN:  prdata = {31'b0, r_enable};
            default: prdata = '0;
        endcase
    end

    // Classify requests and latch samples
    bpc_front #(
        .ADC_WIDTH (ADC_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_mode      (i_mode),
        .i_raw_value (i_raw_value),
        .i_enable    (r_enable),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // Hold pending compute jobs so either side can stall on its own
    bpc_queue #(
        .W     (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    // Run the compensation and present the result
    bpc_back #(
        .ADC_WIDTH (ADC_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coefs     (r_coefs),
        .i_job_valid (q_valid),
        .i_job_d1    (q_data[JOB_W-1:ADC_WIDTH]),
        .i_job_d2    (q_data[ADC_WIDTH-1:0]),
        .o_job_pop   (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_pressure  (o_pressure)
    );

endmodule

@@ test/baro_pressure_compensation_tb.sv @@
// Self-checking testbench for baro_pressure_compensation: random and directed
// sample/sync requests, calibration through the APB port, predicted pressures.
// Depends on bpc_pkg and the baro_pressure_compensation RTL.
module baro_pressure_compensation_tb;
    import bpc_pkg::*;

    localparam int ADC_W         = 24;
    localparam int SETTLE_CYCLES = 64;      // margin for the last jobs to drain
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [2:0] REG_SPARE = 3'd7; // word past the register file

    // Datasheet example calibration words
    localparam t_coefs TYPICAL_COEFS = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                         c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

    typedef struct {
        t_mode            mode;
        logic [RAW_W-1:0] raw;
        bit               hold;     // wait for every pressure to arrive first
    } t_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_mode = MODE_NONE;
    logic [RAW_W-1:0]   i_raw_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [PRESS_W-1:0] o_pressure;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Requests waiting to be driven, and pressures waiting to be seen
    t_event             event_queue[$];
    logic [PRESS_W-1:0] expected_pressure[$];

    // Shadow of the block: calibration, enable and the two latched samples
    t_coefs             cal_words = '0;
    bit                 result_enable = 1'b0;
    logic [RAW_W-1:0]   held_press_raw = '0;
    logic [RAW_W-1:0]   held_temp_raw = '0;

    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 sender_idle_pct = 37;
    int                 receiver_idle_pct = 82;
    int                 events_issued = 0;
    bit                 hold_next = 1'b0;
    bit                 event_taken = 1'b0;
    logic [PRESS_W-1:0] pressure_due;

    baro_pressure_compensation #(.ADC_WIDTH(ADC_W)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_raw_value (i_raw_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pressure  (o_pressure),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // Second-order compensation in exact 64-bit integer arithmetic. SV signed
    // division truncates toward zero, which is what every step here wants.
    function automatic logic [PRESS_W-1:0] compensated_pressure(
        t_coefs c, logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        longint dt, off, sens, temp, t, u, off2, sens2, p;
        dt   = longint'(d2) - longint'(c.c5) * 256;
        off  = (longint'(c.c2) * 8388608 + longint'(c.c4) * dt) / 128;
        sens = (longint'(c.c1) * 8388608 + longint'(c.c3) * dt) / 256;
        temp = (longint'(2000) * 8388608 + longint'(c.c6) * dt) / 8388608;
        // Cold correction below 20.00 C, with a harder term below -15.00 C
        if (temp < 2000) begin
            t     = temp - 2000;
            off2  = (5 * t * t) / 2;
            sens2 = off2 / 2;
            if (temp < -1500) begin
                u     = temp + 1500;
                off2  = off2 + 7 * u * u;
                sens2 = sens2 + (11 * u * u) / 2;
            end
            off  = off - off2;
            sens = sens - sens2;
        end
        p = (longint'(d1) * sens - off * 2097152) / (longint'(1) << 36);
        return p[PRESS_W-1:0];
    endfunction

    // Raw readings: the rails, the band around the reference temperature, or anything
    function automatic logic [RAW_W-1:0] rand_raw();
        int v;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: begin
                v = int'(cal_words.c5) * 256 + int'($urandom_range(4000000)) - 2000000;
                if (v < 0) v = 0;
                if (v > 24'hFFFFFF) v = 24'hFFFFFF;
                return RAW_W'(v);
            end
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic void push_event(t_mode m, logic [RAW_W-1:0] raw);
        t_event ev;
        ev.mode   = m;
        ev.raw    = raw;
        ev.hold   = hold_next;
        hold_next = 1'b0;
        event_queue.push_back(ev);
        if (m != MODE_NONE) events_issued++;
    endfunction

    // Mostly complete measurement cycles with random content, the rest noise
    task automatic queue_random_events(int n);
        int    target;
        bit    held;
        t_mode m;
        target = events_issued + n;
        held   = 1'b0;
        while (events_issued < target) begin
            if (!held && events_issued >= target - n / 2) begin
                hold_next = 1'b1;
                held      = 1'b1;
            end
            if ($urandom_range(99) < 75) begin
                case ($urandom_range(3))
                    0: begin
                        push_event(MODE_PRESS, rand_raw());
                        push_event(MODE_TEMP, rand_raw());
                    end
                    1: begin
                        push_event(MODE_TEMP, rand_raw());
                        push_event(MODE_PRESS, rand_raw());
                    end
                    2: push_event(MODE_TEMP, rand_raw());
                    default: push_event(MODE_PRESS, rand_raw());
                endcase
                push_event(MODE_SYNC, RAW_W'($urandom));
            end else begin
                m = t_mode'($urandom_range(3));
                push_event(m, RAW_W'($urandom));
            end
        end
    endtask

    // Setup then access phase; the register takes the data at the access edge
    task automatic apb_write(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (t_reg_idx'(idx))
            REG_C1: cal_words.c1 = data[COEF_W-1:0];
            REG_C2: cal_words.c2 = data[COEF_W-1:0];
            REG_C3: cal_words.c3 = data[COEF_W-1:0];
            REG_C4: cal_words.c4 = data[COEF_W-1:0];
            REG_C5: cal_words.c5 = data[COEF_W-1:0];
            REG_C6: cal_words.c6 = data[COEF_W-1:0];
            REG_EN: result_enable = data[0];
            default: ;
        endcase
    endtask

    // Junk in the upper data bits checks that each register keeps its own width
    task automatic write_calibration(t_coefs c, bit en);
        apb_write(REG_C1, {16'($urandom), c.c1});
        apb_write(REG_C2, {16'($urandom), c.c2});
        apb_write(REG_C3, {16'($urandom), c.c3});
        apb_write(REG_C4, {16'($urandom), c.c4});
        apb_write(REG_C5, {16'($urandom), c.c5});
        apb_write(REG_C6, {16'($urandom), c.c6});
        apb_write(REG_EN, {31'($urandom), en});
    endtask

    // Wait for every request to go in and every pressure to come out, then let
    // any job that produces nothing run dry before touching the registers
    task automatic wait_for_quiet();
        do @(posedge i_clk);
        while (event_queue.size() != 0 || i_in_valid || expected_pressure.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: hold a stalled request, otherwise advance or idle at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || event_taken) begin
            if (event_queue.size() != 0
                    && !(event_queue[0].hold && expected_pressure.size() != 0)
                    && $urandom_range(99) >= sender_idle_pct) begin
                i_in_valid  <= 1'b1;
                i_mode      <= event_queue[0].mode;
                i_raw_value <= event_queue[0].raw;
                void'(event_queue.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, independent of anything else
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // Monitor: check pressures first, then fold the accepted request into the
    // shadow, so a sync taken this edge never matches a result of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_pressure.size() == 0) begin
                    $error("pressure: expected none, got %0d", $signed(o_pressure));
                    error_count++;
                end else begin
                    pressure_due = expected_pressure.pop_front();
                    if (o_pressure !== pressure_due) begin
                        $error("pressure: expected %0d, got %0d",
                               $signed(pressure_due), $signed(o_pressure));
                        error_count++;
                    end
                end
            end
            event_taken = i_in_valid && !o_in_stall;
            if (event_taken) begin
                case (t_mode'(i_mode))
                    MODE_PRESS: held_press_raw = i_raw_value[ADC_W-1:0];
                    MODE_TEMP:  held_temp_raw = i_raw_value[ADC_W-1:0];
                    MODE_SYNC: begin
                        if (result_enable)
                            expected_pressure.push_back(compensated_pressure(
                                cal_words, held_press_raw, held_temp_raw));
                    end
                    default: ;
                endcase
            end
        end else begin
            event_taken = 1'b0;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_coefs coefs;
        bit     en;
        int     n;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset calibration, output off: syncs and dropped requests yield nothing
        push_event(MODE_SYNC, '0);
        push_event(MODE_NONE, '1);
        push_event(MODE_SYNC, 24'h123456);
        wait_for_quiet();

        write_calibration(TYPICAL_COEFS, 1'b1);
        apb_write(REG_SPARE, $urandom);

        // Sync on the reset zeros, then rails, the 20.00 C edge and the deep cold
        push_event(MODE_SYNC, '1);
        push_event(MODE_PRESS, '1);
        push_event(MODE_TEMP, '1);
        push_event(MODE_SYNC, '0);
        push_event(MODE_TEMP, '0);
        push_event(MODE_SYNC, '0);
        push_event(MODE_PRESS, '0);
        push_event(MODE_SYNC, '0);
        push_event(MODE_NONE, '1);
        push_event(MODE_SYNC, '0);
        push_event(MODE_PRESS, 24'd9085466);
        push_event(MODE_TEMP, 24'(int'(TYPICAL_COEFS.c5) * 256));
        push_event(MODE_SYNC, '0);
        push_event(MODE_TEMP, 24'(int'(TYPICAL_COEFS.c5) * 256 - 1));
        push_event(MODE_SYNC, '1);
        push_event(MODE_TEMP, 24'd7000000);
        push_event(MODE_SYNC, '0);
        push_event(MODE_PRESS, 24'hA5A5A5);
        push_event(MODE_TEMP, 24'h5A5A5A);
        push_event(MODE_SYNC, '1);
        wait_for_quiet();

        // Random phases, each under its own calibration and one of three idling patterns
        for (int ph = 0; ph < 7; ph++) begin
            en = 1'b1;
            n  = 130;
            case (ph)
                0: coefs = TYPICAL_COEFS;
                1: coefs = '1;
                2: coefs = '0;
                4: begin
                    coefs = t_coefs'({$urandom, $urandom, $urandom});
                    en    = 1'b0;
                    n     = 60;
                end
                6: coefs = '{c1: 16'($urandom), c2: 16'($urandom), c3: 16'($urandom),
                             c4: 16'($urandom), c5: 16'hFFFF, c6: 16'hFFFF};
                default: coefs = t_coefs'({$urandom, $urandom, $urandom});
            endcase
            if (ph < 2) begin
                sender_idle_pct   = 37;
                receiver_idle_pct = 82;
            end else if (ph < 4) begin
                sender_idle_pct   = 82;
                receiver_idle_pct = 37;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            write_calibration(coefs, en);
            queue_random_events(n);
            wait_for_quiet();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
